>>> rtl/core/euu_pkg.sv
// Package for the escape decoder: the queue command type, the escape-state codes,
// the character constants, and the UTF-8 encoding and hex-digit functions.
// It has no dependencies and is compiled first.
package euu_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_UPPER_U   = 8'h55;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    localparam logic [3:0] DIGITS_SHORT = 4'd4;
    localparam logic [3:0] DIGITS_LONG  = 4'd8;

    localparam logic [31:0] REPL_CHAR  = 32'h0000_FFFD;
    localparam logic [31:0] SURR_LO    = 32'h0000_D800;
    localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
    localparam logic [31:0] CODE_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] LIMIT_1B   = 32'h0000_0080;
    localparam logic [31:0] LIMIT_2B   = 32'h0000_0800;
    localparam logic [31:0] LIMIT_3B   = 32'h0001_0000;
    localparam logic [7:0]  LEAD_2B    = 8'hC0;
    localparam logic [7:0]  LEAD_3B    = 8'hE0;
    localparam logic [7:0]  LEAD_4B    = 8'hF0;
    localparam logic [7:0]  CONT_BYTE  = 8'h80;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_ESC   = 3'b010,
        PH_HEX   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
    } t_utf8;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            eos;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h57);
        end
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [31:0] ch_in);
        logic [31:0] ch;
        t_utf8       r;
        ch = ch_in;
        r  = '0;
        if ((ch >= SURR_LO && ch <= SURR_HI) || ch > CODE_MAX) begin
            ch = REPL_CHAR;
        end
        if (ch < LIMIT_1B) begin
            r.bytes[0] = ch[7:0];
            r.nbytes   = 3'd1;
        end else if (ch < LIMIT_2B) begin
            r.bytes[0] = LEAD_2B | {3'b000, ch[10:6]};
            r.bytes[1] = CONT_BYTE | {2'b00, ch[5:0]};
            r.nbytes   = 3'd2;
        end else if (ch < LIMIT_3B) begin
            r.bytes[0] = LEAD_3B | {4'b0000, ch[15:12]};
            r.bytes[1] = CONT_BYTE | {2'b00, ch[11:6]};
            r.bytes[2] = CONT_BYTE | {2'b00, ch[5:0]};
            r.nbytes   = 3'd3;
        end else begin
            r.bytes[0] = LEAD_4B | {5'b00000, ch[20:18]};
            r.bytes[1] = CONT_BYTE | {2'b00, ch[17:12]};
            r.bytes[2] = CONT_BYTE | {2'b00, ch[11:6]};
            r.bytes[3] = CONT_BYTE | {2'b00, ch[5:0]};
            r.nbytes   = 3'd4;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/euu_intf.sv
// Stream interfaces for the escape decoder: the raw-byte input channel and the
// decoded-byte output channel, each with valid, ready and payload. No dependencies.
interface euu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_marker;

    modport source (output valid, output in_byte, output end_marker, input ready);
    modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface euu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       string_end;

    modport source (output valid, output out_byte, output byte_valid, output last,
                     output string_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                     input string_end, output ready);
endinterface

>>> rtl/core/euu_front.sv
// Front end of the escape decoder: accepts input transactions, tracks the escape
// state and per transaction pushes at most one command: up to four bytes and an end flag.
// Depends on euu_pkg and euu_in_if.
module euu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    euu_in_if.sink          i_in,
    input  logic            i_q_ready,
    output logic            o_push,
    output euu_pkg::t_cmd   o_cmd
);

    euu_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_digits, n_digits;
    logic [31:0]     r_acc, n_acc;
    logic            r_crlf;

    euu_pkg::t_hex   hv;
    euu_pkg::t_utf8  enc;
    logic [31:0]     acc_shift;
    logic [31:0]     enc_src;
    logic [3:0]      digits_dec;
    logic            accept;
    euu_pkg::t_cmd   cmd;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    assign hv         = euu_pkg::hex_decode(i_in.in_byte);
    assign acc_shift  = {r_acc[27:0], hv.value};
    assign digits_dec = (r_digits != 4'd0) ? (r_digits - 4'd1) : 4'd0;
    assign enc_src    = i_in.end_marker ? r_acc : acc_shift;
    assign enc        = euu_pkg::utf8_encode(enc_src);

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_acc    = r_acc;
        cmd      = '0;
        if (i_in.end_marker) begin
            if (r_phase == euu_pkg::PH_HEX) begin
                cmd.bytes  = enc.bytes;
                cmd.nbytes = enc.nbytes;
            end
            cmd.eos  = 1'b1;
            n_phase  = euu_pkg::PH_PLAIN;
            n_digits = 4'd0;
            n_acc    = 32'd0;
        end else begin
            unique case (r_phase)
                euu_pkg::PH_ESC: begin
                    n_phase = euu_pkg::PH_PLAIN;
                    case (i_in.in_byte)
                        euu_pkg::CH_LOWER_N: begin
                            if (r_crlf) begin
                                cmd.bytes[0] = euu_pkg::CH_CR;
                                cmd.bytes[1] = euu_pkg::CH_LF;
                                cmd.nbytes   = 3'd2;
                            end else begin
                                cmd.bytes[0] = euu_pkg::CH_LF;
                                cmd.nbytes   = 3'd1;
                            end
                        end
                        euu_pkg::CH_LOWER_T: begin
                            cmd.bytes[0] = euu_pkg::CH_TAB;
                            cmd.nbytes   = 3'd1;
                        end
                        euu_pkg::CH_LOWER_U: begin
                            n_phase  = euu_pkg::PH_HEX;
                            n_digits = euu_pkg::DIGITS_SHORT;
                            n_acc    = 32'd0;
                        end
                        euu_pkg::CH_UPPER_U: begin
                            n_phase  = euu_pkg::PH_HEX;
                            n_digits = euu_pkg::DIGITS_LONG;
                            n_acc    = 32'd0;
                        end
                        default: begin
                            cmd.bytes[0] = i_in.in_byte;
                            cmd.nbytes   = 3'd1;
                        end
                    endcase
                end
                euu_pkg::PH_HEX: begin
                    if (!hv.ok) begin
                        n_phase      = euu_pkg::PH_PLAIN;
                        n_digits     = 4'd0;
                        cmd.bytes[0] = 8'hEF;
                        cmd.bytes[1] = 8'hBF;
                        cmd.bytes[2] = 8'hBD;
                        cmd.nbytes   = 3'd3;
                        if (i_in.in_byte == euu_pkg::CH_BACKSLASH) begin
                            n_phase = euu_pkg::PH_ESC;
                        end else begin
                            cmd.bytes[3] = i_in.in_byte;
                            cmd.nbytes   = 3'd4;
                        end
                    end else begin
                        n_acc    = acc_shift;
                        n_digits = digits_dec;
                        if (digits_dec == 4'd0) begin
                            n_phase    = euu_pkg::PH_PLAIN;
                            cmd.bytes  = enc.bytes;
                            cmd.nbytes = enc.nbytes;
                        end
                    end
                end
                default: begin
                    n_phase = euu_pkg::PH_PLAIN;
                    if (i_in.in_byte == euu_pkg::CH_BACKSLASH) begin
                        n_phase = euu_pkg::PH_ESC;
                    end else begin
                        cmd.bytes[0] = i_in.in_byte;
                        cmd.nbytes   = 3'd1;
                    end
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.eos || (cmd.nbytes != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= euu_pkg::PH_PLAIN;
            r_digits <= 4'd0;
            r_acc    <= 32'd0;
            r_crlf   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_digits <= n_digits;
                r_acc    <= n_acc;
            end
            if (i_cfg_wr_en) begin
                r_crlf <= i_cfg_wr_data;
            end
        end
    end

endmodule

>>> rtl/core/euu_queue.sv
// Command queue between the front and back ends of the escape decoder.
// A small register-based FIFO of euu_pkg::t_cmd entries.
module euu_queue #(
    parameter int DEPTH = euu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  euu_pkg::t_cmd   i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output euu_pkg::t_cmd   o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    euu_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/euu_back.sv
// Back end of the escape decoder: takes commands from the queue and sends their
// bytes, then any end notice, one output transaction per cycle while ready is high.
// Depends on euu_pkg and euu_out_if.
module euu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  euu_pkg::t_cmd   i_q_cmd,
    output logic            o_q_pop,
    euu_out_if.source       o_out
);

    logic          r_busy;
    euu_pkg::t_cmd r_cmd;
    logic [2:0]    r_idx;

    logic [2:0]    total;
    logic          is_last;
    logic          data_sel;
    logic          load;

    assign total    = r_cmd.nbytes + {2'b00, r_cmd.eos};
    assign is_last  = ((r_idx + 3'd1) == total);
    assign data_sel = (r_idx < r_cmd.nbytes);
    assign load     = i_q_valid && (!r_busy || (o_out.ready && is_last));
    assign o_q_pop  = load;

    assign o_out.valid      = r_busy;
    assign o_out.out_byte   = data_sel ? r_cmd.bytes[r_idx[1:0]] : 8'h00;
    assign o_out.byte_valid = data_sel;
    assign o_out.string_end = !data_sel;
    assign o_out.last       = is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && o_out.ready) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

>>> rtl/core/escape_unescape_utf8.sv
// Top level of the backslash-escape decoder with UTF-8 encoder.
// Depends on euu_pkg, euu_intf, euu_front, euu_queue and euu_back.
//
// Usage: i_in carries one raw text byte per transaction, or an end marker that
// flushes a pending escape. o_out carries the decoded bytes, one per transaction;
// last marks the final output caused by an input transaction, and an end marker
// gives a final transaction with byte_valid low and string_end high.
// The newline mode (LF or CR LF for an escaped n) is set by i_cfg_wr_en and
// i_cfg_wr_data, by the user only while idle; the block does not enforce it.
// An accepted transaction's command enters the queue, then the back end's command
// register, before its first result appears. Throughput: one input transaction per
// cycle while the queue has room; the output side sends one result per cycle while
// the receiver is ready, and a transaction expands into up to five results.
// A stalled receiver holds the current result; the queue of QUEUE_DEPTH commands
// keeps accepting input until it fills, then input ready drops.
// Reset is synchronous and active low; it empties the queue, returns the escape
// state to plain text and selects LF-only newlines.
module escape_unescape_utf8 #(
    parameter int QUEUE_DEPTH = euu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    euu_in_if.sink    i_in,
    euu_out_if.source o_out
);

    logic          push, q_ready, q_valid, q_pop;
    euu_pkg::t_cmd push_cmd, q_cmd;

    euu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    euu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    euu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

>>> verif/euu_checker.sv
`timescale 1ns / 1ps
// Checker for the escape decoder: watches the input, output and newline-mode ports,
// predicts the decoded bytes of every input transaction and compares them in order.
// Depends on euu_pkg and the stream interfaces in euu_intf.
module euu_checker
    import euu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    euu_in_if    i_in_mon,
    euu_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       byte_flag;
        logic       last;
        logic       str_end;
    } t_decoded;

    t_phase      esc_phase;
    logic [3:0]  digits_left;
    logic [31:0] code_acc;
    logic        crlf_mode;
    t_decoded    expected_bytes[$];
    t_decoded    step_bytes[$];
    t_decoded    want;
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void emit(input logic [7:0] b, input logic bv, input logic se);
        t_decoded d;
        d.data      = b;
        d.byte_flag = bv;
        d.last      = 1'b0;
        d.str_end   = se;
        step_bytes  = {step_bytes, d};
    endfunction

    function automatic int nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic void encode_utf8(input logic [31:0] code_in);
        logic [31:0] ch;
        ch = code_in;
        if ((ch >= SURR_LO && ch <= SURR_HI) || ch > CODE_MAX) ch = REPL_CHAR;
        if (ch < LIMIT_1B) begin
            emit(ch[7:0], 1'b1, 1'b0);
        end else if (ch < LIMIT_2B) begin
            emit(LEAD_2B | 8'(ch >> 6), 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[5:0]}, 1'b1, 1'b0);
        end else if (ch < LIMIT_3B) begin
            emit(LEAD_3B | 8'(ch >> 12), 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[11:6]}, 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[5:0]}, 1'b1, 1'b0);
        end else begin
            emit(LEAD_4B | 8'(ch >> 18), 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[17:12]}, 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[11:6]}, 1'b1, 1'b0);
            emit(CONT_BYTE | {2'b00, ch[5:0]}, 1'b1, 1'b0);
        end
    endfunction

    function automatic void plain_char(input logic [7:0] b);
        if (b == CH_BACKSLASH) esc_phase = PH_ESC;
        else emit(b, 1'b1, 1'b0);
    endfunction

    function automatic void predict_transaction(input logic [7:0] b, input logic end_mark);
        int v;
        step_bytes.delete();
        if (end_mark) begin
            if (esc_phase == PH_HEX) encode_utf8(code_acc);
            esc_phase   = PH_PLAIN;
            digits_left = '0;
            code_acc    = '0;
            emit(8'h00, 1'b0, 1'b1);
        end else if (esc_phase == PH_ESC) begin
            esc_phase = PH_PLAIN;
            case (b)
                CH_BACKSLASH, CH_SPACE, CH_HASH: emit(b, 1'b1, 1'b0);
                CH_LOWER_N: begin
                    if (crlf_mode) emit(CH_CR, 1'b1, 1'b0);
                    emit(CH_LF, 1'b1, 1'b0);
                end
                CH_LOWER_T: emit(CH_TAB, 1'b1, 1'b0);
                CH_LOWER_U: begin
                    esc_phase   = PH_HEX;
                    digits_left = DIGITS_SHORT;
                    code_acc    = '0;
                end
                CH_UPPER_U: begin
                    esc_phase   = PH_HEX;
                    digits_left = DIGITS_LONG;
                    code_acc    = '0;
                end
                default: plain_char(b);
            endcase
        end else if (esc_phase == PH_HEX) begin
            v = nibble_of(b);
            if (v < 0) begin
                esc_phase   = PH_PLAIN;
                digits_left = '0;
                encode_utf8(REPL_CHAR);
                plain_char(b);
            end else begin
                code_acc = (code_acc << 4) + 32'(v);
                if (digits_left > 0) digits_left = digits_left - 4'd1;
                if (digits_left == 0) begin
                    esc_phase = PH_PLAIN;
                    encode_utf8(code_acc);
                end
            end
        end else begin
            esc_phase = PH_PLAIN;
            plain_char(b);
        end
        if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
        expected_bytes = {expected_bytes, step_bytes};
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            esc_phase   = PH_PLAIN;
            digits_left = '0;
            code_acc    = '0;
            crlf_mode   = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_wr_en) crlf_mode = i_cfg_wr_data;
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_transaction(i_in_mon.in_byte, i_in_mon.end_marker);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output transaction: out_byte %0h", i_out_mon.out_byte);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", want.data, i_out_mon.out_byte);
                    check_field("byte_valid", 8'(want.byte_flag), 8'(i_out_mon.byte_valid));
                    check_field("last", 8'(want.last), 8'(i_out_mon.last));
                    check_field("string_end", 8'(want.str_end), 8'(i_out_mon.string_end));
                end
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the escape decoder testbench: clock, reset, directed and random byte streams,
// random stalls on both channels, newline-mode writes and the final verdict.
// Depends on euu_pkg, euu_intf, escape_unescape_utf8 and euu_checker.
module tb_top;
    import euu_pkg::*;

    localparam int          RANDOM_ITEMS = 470;
    localparam int          RUN_PHASES   = 4;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [8:0]  END_ITEM     = 9'h100;
    localparam logic [7:0]  CH_DIGIT_0   = 8'h30;
    localparam logic [7:0]  CH_UPPER_A   = 8'h41;
    localparam logic [7:0]  CH_LOWER_A   = 8'h61;
    localparam logic [31:0] CODE_EDGES [0:11] = '{
        32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF,
        32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000, 32'hFFFFFFFF
    };

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    bit   in_idle_en;
    bit   out_idle_en;
    int   fail_count;
    int   pending_count;
    int   items_sent = 0;
    int   cycle_count = 0;

    euu_in_if  in_if ();
    euu_out_if out_if ();

    escape_unescape_utf8 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    euu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_mon      (in_if),
        .i_out_mon     (out_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("escape_unescape_utf8: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (out_idle_en) out_if.ready <= ($urandom_range(99) >= 18);
        else out_if.ready <= 1'b1;
    end

    // Called and returning at a falling edge; it sets valid and leaves it high.
    task automatic send_item(input logic [7:0] b, input logic end_mark);
        if (in_idle_en) begin
            while ($urandom_range(99) < 18) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_if.valid      <= 1'b1;
        in_if.in_byte    <= b;
        in_if.end_marker <= end_mark;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_newline_mode(input logic crlf);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= crlf;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_DIGIT_0 + 8'(nib);
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [31:0] pick_code();
        case ($urandom_range(6))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3: return $urandom_range(32'hDFFF, 32'hD800);
            4: return $urandom_range(32'h10FFFF, 32'h10000);
            5: return $urandom();
            default: return CODE_EDGES[$urandom_range(11)];
        endcase
    endfunction

    // Sends the lowest ndig nibbles of code, most significant first.
    task automatic send_hex_digits(input logic [31:0] code, input int ndig);
        for (int i = ndig - 1; i >= 0; i--) send_item(hex_char(code[4*i +: 4]), 1'b0);
    endtask

    task automatic send_hex_opener(input bit long_form);
        send_item(CH_BACKSLASH, 1'b0);
        send_item(long_form ? CH_UPPER_U : CH_LOWER_U, 1'b0);
    endtask

    task automatic send_random_sequence();
        int         kind;
        int         ndig;
        bit         long_form;
        logic [7:0] b;
        logic [7:0] simple_esc [0:4];
        simple_esc = '{CH_BACKSLASH, CH_SPACE, CH_HASH, CH_LOWER_N, CH_LOWER_T};
        kind      = $urandom_range(99);
        long_form = $urandom_range(1);
        ndig      = long_form ? 8 : 4;
        if (kind < 25) begin
            do b = 8'($urandom_range(255)); while (b == CH_BACKSLASH);
            send_item(b, 1'b0);
        end else if (kind < 40) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(simple_esc[$urandom_range(4)], 1'b0);
        end else if (kind < 70) begin
            send_hex_opener(kind >= 55);
            send_hex_digits(pick_code(), kind >= 55 ? 8 : 4);
        end else if (kind < 78) begin
            send_hex_opener(long_form);
            send_hex_digits($urandom(), $urandom_range(ndig - 1));
            if ($urandom_range(3) == 0) begin
                b = CH_BACKSLASH;
            end else begin
                do b = 8'($urandom_range(255));
                while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                       (b >= 8'h61 && b <= 8'h66));
            end
            send_item(b, 1'b0);
        end else if (kind < 85) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
        end else if (kind < 93) begin
            case ($urandom_range(2))
                0: send_item(CH_BACKSLASH, 1'b0);
                1: begin
                    send_hex_opener(long_form);
                    send_hex_digits($urandom(), $urandom_range(ndig - 1));
                end
                default: ;
            endcase
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
    endtask

    initial begin
        logic [8:0] directed [$];
        in_if.valid      = 1'b0;
        in_if.in_byte    = '0;
        in_if.end_marker = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 1'b0;
        in_idle_en       = 1'b0;
        out_idle_en      = 1'b0;
        i_rst_n          = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_newline_mode(1'b0);

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        directed = '{9'h000, 9'h0FF,
                     9'(CH_BACKSLASH), 9'(CH_HASH), 9'(CH_BACKSLASH), 9'(CH_LOWER_N),
                     9'(CH_BACKSLASH), 9'(CH_LOWER_T), 9'(CH_BACKSLASH), 9'(CH_BACKSLASH),
                     9'(CH_BACKSLASH), 9'(CH_SPACE), 9'(CH_BACKSLASH), 9'h071,
                     9'(CH_BACKSLASH), 9'(CH_LOWER_U), 9'h044, 9'h038, 9'h030, 9'h030,
                     9'(CH_BACKSLASH), 9'(CH_LOWER_U), 9'h067,
                     9'(CH_BACKSLASH), END_ITEM,
                     9'(CH_BACKSLASH), 9'(CH_LOWER_U), END_ITEM};
        foreach (directed[k]) send_item(directed[k][7:0], directed[k][8]);

        for (int p = 0; p < RUN_PHASES; p++) begin
            write_newline_mode(p % 2 == 0);
            in_idle_en  = (p != 1);
            out_idle_en = (p != 1);
            while (items_sent < directed.size() + (p + 1) * RANDOM_ITEMS / RUN_PHASES) begin
                send_random_sequence();
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("escape_unescape_utf8: match");
        end else begin
            $display("escape_unescape_utf8: mismatch");
        end
        $finish;
    end

endmodule
